FILE: design/afbs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and folding tables for the accent folding byte stream.
package afbs_pkg;

    localparam int ChWidth   = 7;
    localparam int FifoDepth = 4;
    localparam int PtrWidth  = $clog2(FifoDepth);
    localparam int CntWidth  = PtrWidth + 1;
    localparam int AddrWidth = 3;

    // Register byte addresses.
    localparam logic [AddrWidth-1:0] AddrLowerCase = 3'd0;

    // UTF-8 lead bytes of the supported two-byte letters.
    localparam logic [7:0] LeadC2 = 8'hC2;
    localparam logic [7:0] LeadC3 = 8'hC3;
    localparam logic [7:0] LeadC5 = 8'hC5;

    localparam logic [ChWidth-1:0] CaseOffset = 7'h20;
    localparam logic [ChWidth-1:0] NoChar     = 7'h00;

    typedef struct packed {
        logic [ChWidth-1:0] ch;
        logic               valid;
        logic               eos;
    } res_t;

    // Upper-case form of a lower-case letter unless folding to lower case.
    function automatic logic [ChWidth-1:0] cased(input logic [ChWidth-1:0] ch,
                                                 input logic lc);
        cased = lc ? ch : ch - CaseOffset;
    endfunction

    // Latin-1 single byte; zero means unknown.
    function automatic logic [ChWidth-1:0] fold_single(input logic [7:0] c,
                                                       input logic lc);
        logic [ChWidth-1:0] r;
        r = NoChar;
        case (c) inside
            [8'hC0:8'hC5]:                r = cased(7'h61, lc);
            [8'hE0:8'hE5], 8'hAA:         r = 7'h61;
            [8'hC8:8'hCB]:                r = cased(7'h65, lc);
            [8'hE8:8'hEB]:                r = 7'h65;
            [8'hCC:8'hCF]:                r = cased(7'h69, lc);
            [8'hEC:8'hEF]:                r = 7'h69;
            [8'hD2:8'hD6]:                r = cased(7'h6F, lc);
            [8'hF2:8'hF6], 8'hBA:         r = 7'h6F;
            [8'hD9:8'hDC]:                r = cased(7'h75, lc);
            [8'hF9:8'hFC]:                r = 7'h75;
            8'hC7:                        r = cased(7'h63, lc);
            8'hA9, 8'hE7:                 r = 7'h63;
            8'hD1:                        r = cased(7'h6E, lc);
            8'hF1:                        r = 7'h6E;
            8'hAE:                        r = 7'h72;
            8'hDF:                        r = 7'h73;
            8'h8E:                        r = cased(7'h7A, lc);
            8'h9E:                        r = 7'h7A;
            8'h9F, 8'hDD:                 r = cased(7'h79, lc);
            8'hFD, 8'hFF:                 r = 7'h79;
            default:                      r = NoChar;
        endcase
        fold_single = r;
    endfunction

    // Two-byte UTF-8 letter; zero means unknown.
    function automatic logic [ChWidth-1:0] fold_pair(input logic [7:0] lead,
                                                     input logic [7:0] c,
                                                     input logic lc);
        logic [ChWidth-1:0] r;
        r = NoChar;
        if (lead == LeadC2)
        begin
            case (c)
                8'hAA:   r = 7'h61;
                8'hBA:   r = 7'h6F;
                8'hA9:   r = 7'h63;
                8'hAE:   r = 7'h72;
                default: r = NoChar;
            endcase
        end
        else if (lead == LeadC3)
        begin
            case (c) inside
                [8'h80:8'h85]:  r = cased(7'h61, lc);
                [8'hA0:8'hA5]:  r = 7'h61;
                [8'h88:8'h8B]:  r = cased(7'h65, lc);
                [8'hA8:8'hAB]:  r = 7'h65;
                [8'h8C:8'h8F]:  r = cased(7'h69, lc);
                [8'hAC:8'hAF]:  r = 7'h69;
                [8'h92:8'h96]:  r = cased(7'h6F, lc);
                [8'hB2:8'hB6]:  r = 7'h6F;
                [8'h99:8'h9C]:  r = cased(7'h75, lc);
                [8'hB9:8'hBC]:  r = 7'h75;
                8'h87:          r = cased(7'h63, lc);
                8'hA7:          r = 7'h63;
                8'h91:          r = cased(7'h6E, lc);
                8'hB1:          r = 7'h6E;
                8'h9F:          r = 7'h73;
                8'h9D:          r = cased(7'h79, lc);
                8'hBD, 8'hBF:   r = 7'h79;
                default:        r = NoChar;
            endcase
        end
        else if (lead == LeadC5)
        begin
            case (c)
                8'hBD:   r = cased(7'h7A, lc);
                8'hBE:   r = 7'h7A;
                8'hB8:   r = cased(7'h79, lc);
                default: r = NoChar;
            endcase
        end
        fold_pair = r;
    endfunction

endpackage

FILE: design/accent_folding_byte_stream.sv
`timescale 1ns / 1ps
// Top level of the accent folding byte stream: input register, fold logic, result queue.
//
// Usage:
//   Slave stream s_*: one raw string byte per transaction in s_tdata, s_tlast on the
//   final byte of the string. Master stream m_*: one folded ASCII character per
//   transaction in m_tdata[6:0]; m_tuser is 1 when the character is real and 0 for a
//   bare end marker; m_tlast marks the last result of a string.
//   APB port: register lower_case at byte address 0 (bit 0). Write it only while the
//   stream is idle.
// Flow: a byte is captured in the input register, folded by combinational logic and then
//   written to the result queue, whose head drives m_*. Bytes that only open a
//   UTF-8 pair produce no result until the following byte arrives.
// Throughput: one byte per cycle. A pending Latin-1 byte followed by an ASCII byte
//   yields two results; the four-entry result queue absorbs them, and the input only
//   stalls when the queue lacks room for the results of the held byte.
// Reset: clears the input register valid flag, the pending high byte, the queue and lower_case.
// Stall: when m_tready is low, results accumulate in the queue; once it lacks room the
//   input register holds and s_tready drops. No result is ever dropped.
module accent_folding_byte_stream (
    input  logic                                clk,
    input  logic                                rst_n,
    // slave stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] byte_in
    input  logic                                s_tlast,   // last_byte
    // master stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [6:0] char_out, [7] zero
    output logic                                m_tuser,   // [0] char_valid
    output logic                                m_tlast,   // end_of_string
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [afbs_pkg::AddrWidth-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import afbs_pkg::*;

    // Configuration
    logic lower_case_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_case_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr == AddrLowerCase)
        begin
            lower_case_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr == AddrLowerCase) ? {31'b0, lower_case_reg} : 32'b0;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       fold_fire;

    assign s_tready = !in_valid_reg || fold_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Pending high byte, waiting to see whether it opens a UTF-8 pair
    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_byte_reg, pend_byte_next;

    // Fold logic
    logic [ChWidth-1:0] f_pair;
    logic [ChWidth-1:0] f_single_in;
    logic [ChWidth-1:0] f_single_pend;
    logic [ChWidth-1:0] ascii_ch;
    res_t               res0, res1;
    logic [1:0]         n_res;

    assign f_pair        = fold_pair(pend_byte_reg, in_byte_reg, lower_case_reg);
    assign f_single_in   = fold_single(in_byte_reg, lower_case_reg);
    assign f_single_pend = fold_single(pend_byte_reg, lower_case_reg);

    // Lower an ASCII capital when folding to lower case.
    assign ascii_ch = (lower_case_reg && in_byte_reg[6:0] >= 7'h41 && in_byte_reg[6:0] <= 7'h5A)
                    ? in_byte_reg[6:0] + CaseOffset : in_byte_reg[6:0];

    always_comb
    begin
        res0            = '0;
        res1            = '0;
        n_res           = 2'd0;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        if (in_byte_reg[7])
        begin
            if (pend_valid_reg)
            begin
                // close the pair; an unknown pair drops both bytes
                pend_valid_next = 1'b0;
                pend_byte_next  = 8'h00;
                if (f_pair != NoChar)
                begin
                    res0  = '{ch: f_pair, valid: 1'b1, eos: 1'b0};
                    n_res = 2'd1;
                end
            end
            else if (in_last_reg)
            begin
                // nothing can follow: resolve as Latin-1 now
                if (f_single_in != NoChar)
                begin
                    res0  = '{ch: f_single_in, valid: 1'b1, eos: 1'b0};
                    n_res = 2'd1;
                end
            end
            else
            begin
                pend_valid_next = 1'b1;
                pend_byte_next  = in_byte_reg;
            end
        end
        else
        begin
            if (pend_valid_reg)
            begin
                pend_valid_next = 1'b0;
                pend_byte_next  = 8'h00;
            end
            if (pend_valid_reg && f_single_pend != NoChar)
            begin
                res0  = '{ch: f_single_pend, valid: 1'b1, eos: 1'b0};
                res1  = '{ch: ascii_ch, valid: 1'b1, eos: 1'b0};
                n_res = 2'd2;
            end
            else
            begin
                res0  = '{ch: ascii_ch, valid: 1'b1, eos: 1'b0};
                n_res = 2'd1;
            end
        end
        if (in_last_reg)
        begin
            // flag the final result, or emit a bare end marker
            if (n_res == 2'd0)
            begin
                res0  = '{ch: NoChar, valid: 1'b0, eos: 1'b1};
                n_res = 2'd1;
            end
            else if (n_res == 2'd1)
            begin
                res0.eos = 1'b1;
            end
            else
            begin
                res1.eos = 1'b1;
            end
        end
    end

    // Result queue
    res_t                fifo_reg [FifoDepth];
    logic [PtrWidth-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntWidth-1:0] count_reg, count_next;
    logic [CntWidth-1:0] room_need;
    logic [PtrWidth-1:0] wr_ptr_plus1;
    logic                pop;

    // Advance only when the queue has room for every result of the held byte.
    assign room_need = count_reg + CntWidth'(n_res);
    assign fold_fire = in_valid_reg && (room_need <= CntWidth'(FifoDepth));
    assign pop       = m_tvalid && m_tready;
    assign wr_ptr_plus1 = wr_ptr_reg + PtrWidth'(1);

    always_comb
    begin
        count_next = count_reg;
        if (fold_fire)
        begin
            count_next = count_next + CntWidth'(n_res);
        end
        if (pop)
        begin
            count_next = count_next - CntWidth'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_byte_reg  <= 8'h00;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (fold_fire)
            begin
                pend_valid_reg <= pend_valid_next;
                pend_byte_reg  <= pend_byte_next;
                wr_ptr_reg     <= wr_ptr_reg + PtrWidth'(n_res);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PtrWidth'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fold_fire && n_res != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (fold_fire && n_res == 2'd2)
        begin
            fifo_reg[wr_ptr_plus1] <= res1;
        end
    end

    res_t head;

    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {1'b0, head.ch};
    assign m_tuser  = head.valid;
    assign m_tlast  = head.eos;

endmodule
